### rtl/dmtq_pkg.sv
`timescale 1ns / 1ps

package dmtq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	// destination ids at or above this bound are always bad
	localparam int PROCESS_SLOTS   = 16;

	localparam int DEADLINE_W = 32;
	localparam int HANDLE_W   = 8;
	localparam int DEST_W     = 4;
	localparam int STATUS_W   = 3;
	localparam int PCOUNT_W   = 5;
	localparam int LIM_W      = 9;

	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 16;

	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(16);

	typedef enum logic [STATUS_W-1:0] {
		ST_SCHEDULED = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_BAD_DEST  = 3'd4,
		ST_NONE_DUE  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		logic                  occ;
		logic [DEADLINE_W-1:0] deadline;
		logic [HANDLE_W-1:0]   handle;
		logic [DEST_W-1:0]     dest;
	} entry_t;

	// broadcast to every cell; handle doubles as the duplicate probe
	typedef struct packed {
		cell_op_t              op;
		logic [DEADLINE_W-1:0] deadline;
		logic [HANDLE_W-1:0]   handle;
		logic [DEST_W-1:0]     dest;
	} cell_cmd_t;

endpackage

### rtl/delayed_message_timer_queue.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tuser = kind, s_tdata = handle, dest, delay, now
// m_*      out  m_tvalid/m_tready  m_tuser = status, m_tdata = handle, dest, m_tlast
// cfg_*    in   cfg_valid/cfg_ready cfg_data = process_count
//
// Schedule: after accept, a scan state walks the cell chain, then a decide state
//   inserts and reports, and ready returns after decide; the duplicate match flag
//   ripples down the cell chain one cell per cycle.
// Tick: pops due entries until a bad dest or the last due; NONE_DUE if none is due.
// Reset clears all cells to empty and process_count to 16; no clearing pass.
// A stalled output holds the controller; one result may wait in the
//   output register while the next request is taken.

module delayed_message_timer_queue
	import dmtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // handle[7:0] dest[11:8] delay[43:12] now[75:44]
	input  logic                s_tuser,   // kind: 0 schedule, 1 tick
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // out_handle[7:0] out_dest[11:8]
	output logic [STATUS_W-1:0] m_tuser,   // status
	output logic                m_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PCOUNT_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_TICK
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PCOUNT_W-1:0]   pcount_q;
	logic [DEADLINE_W-1:0] deadline_q;
	logic [DEADLINE_W-1:0] now_q;
	logic [HANDLE_W-1:0]   req_handle_q;
	logic [DEST_W-1:0]     req_dest_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [DEST_W-1:0]     out_dest_q;
	logic                  out_last_q;

	cell_cmd_t             cmd;
	entry_t                ent   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] gt_v;
	logic [QUEUE_DEPTH-1:0] hit_v;
	logic [QUEUE_DEPTH-1:0] occ_v;

	logic                  out_free;
	logic                  dup;
	logic                  full;
	logic                  head_due;
	logic                  second_due;
	logic                  head_ok;
	logic [LIM_W-1:0]      lim;

	// ---------------- cell chain ----------------
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_g;
		logic   hit_i;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_g = 1'b0;
			assign hit_i  = 1'b0;
		end else begin : g_body
			assign prev_e = ent[i-1];
			assign prev_g = gt_v[i-1];
			assign hit_i  = hit_v[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = ent[i+1];
		end

		dmtq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_entry (prev_e),
			.prev_gt    (prev_g),
			.next_entry (next_e),
			.hit_in     (hit_i),
			.entry      (ent[i]),
			.gt         (gt_v[i]),
			.hit        (hit_v[i])
		);

		assign occ_v[i] = ent[i].occ;
	end

	// ---------------- decisions ----------------
	assign out_free   = !out_valid_q || m_tready;
	assign dup        = hit_v[QUEUE_DEPTH-1];
	assign full       = occ_v[QUEUE_DEPTH-1];
	assign head_due   = ent[0].occ && (ent[0].deadline <= now_q);
	assign second_due = ent[1].occ && (ent[1].deadline <= now_q);

	// limit is min(process_count, PROCESS_SLOTS)
	assign lim     = (LIM_W'(pcount_q) > LIM_W'(PROCESS_SLOTS)) ? LIM_W'(PROCESS_SLOTS)
		: LIM_W'(pcount_q);
	assign head_ok = LIM_W'(ent[0].dest) < lim;

	always_comb begin
		cmd.deadline = deadline_q;
		cmd.handle   = req_handle_q;
		cmd.dest     = req_dest_q;
		cmd.op       = OP_HOLD;
		if (state_q == S_DECIDE && out_free && !dup && !full) begin
			cmd.op = OP_INSERT;
		end else if (state_q == S_TICK && out_free && head_due) begin
			cmd.op = OP_POP;
		end
	end

	// ---------------- ports ----------------
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tuser   = out_status_q;
	assign m_tdata   = {(M_DATA_W - HANDLE_W - DEST_W)'(0), out_dest_q, out_handle_q};
	assign m_tlast   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= PCOUNT_RESET;
		end else if (cfg_valid) begin
			pcount_q <= cfg_data;
		end
	end

	// request latch, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_handle_q <= s_tdata[7:0];
			req_dest_q   <= s_tdata[11:8];
			now_q        <= s_tdata[75:44];
			deadline_q   <= s_tdata[43:12] + s_tdata[75:44];
		end
	end

	// controller and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_SCHEDULED;
			out_handle_q <= '0;
			out_dest_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= s_tuser ? S_TICK : S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUEUE_DEPTH - 1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_handle_q <= req_handle_q;
						out_dest_q   <= req_dest_q;
						out_last_q   <= 1'b1;
						if (dup) begin
							out_status_q <= ST_DUPLICATE;
						end else if (full) begin
							out_status_q <= ST_FULL;
						end else begin
							out_status_q <= ST_SCHEDULED;
						end
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (head_due) begin
							out_status_q <= head_ok ? ST_RELEASED : ST_BAD_DEST;
							out_handle_q <= ent[0].handle;
							out_dest_q   <= ent[0].dest;
							// bad destination ends the tick
							out_last_q   <= !head_ok || !second_due;
							if (!head_ok || !second_due) begin
								state_q <= S_IDLE;
							end
						end else begin
							out_status_q <= ST_NONE_DUE;
							out_handle_q <= '0;
							out_dest_q   <= '0;
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------- checks ----------------
	// occupied cells always form a contiguous run from the head
	a_occ_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_v + 1'b1) & occ_v) == '0)
		else $error("cell occupancy not contiguous");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INSERT |=> $countones(occ_v) == $past($countones(occ_v)) + 1)
		else $error("insert did not add exactly one entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_POP |=> $countones(occ_v) + 1 == $past($countones(occ_v)))
		else $error("pop did not remove exactly one entry");

	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INSERT |-> !occ_v[QUEUE_DEPTH-1])
		else $error("insert into full queue");

	a_pop_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_POP |-> occ_v[0])
		else $error("pop from empty queue");

endmodule

### rtl/dmtq_cell.sv
`timescale 1ns / 1ps

module dmtq_cell
	import dmtq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  entry_t    prev_entry,
	input  logic      prev_gt,
	input  entry_t    next_entry,
	input  logic      hit_in,
	output entry_t    entry,
	output logic      gt,
	output logic      hit
);

	logic                  occ_q;
	logic [DEADLINE_W-1:0] deadline_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [DEST_W-1:0]     dest_q;
	logic                  hit_q;
	entry_t                nxt;

	assign entry = '{occ: occ_q, deadline: deadline_q, handle: handle_q, dest: dest_q};

	// empty cells count as later than anything
	assign gt  = !occ_q || (deadline_q > cmd.deadline);
	assign hit = hit_q;

	always_comb begin
		nxt = entry;
		case (cmd.op)
			OP_INSERT: begin
				if (gt) begin
					if (prev_gt) begin
						nxt = prev_entry;
					end else begin
						nxt = '{occ: 1'b1, deadline: cmd.deadline, handle: cmd.handle,
							dest: cmd.dest};
					end
				end
			end
			OP_POP: begin
				nxt = next_entry;
			end
			default: begin
				nxt = entry;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			occ_q <= nxt.occ;
			// match flag ripples one cell per cycle toward the tail
			hit_q <= hit_in || (occ_q && (handle_q == cmd.handle));
		end
	end

	always_ff @(posedge clk) begin
		deadline_q <= nxt.deadline;
		handle_q   <= nxt.handle;
		dest_q     <= nxt.dest;
	end

endmodule
